// ----- design/ctm_pkg.sv -----
// ----------------------------------------------------------------------------
// ctm_pkg
// Shared types, widths and the sRGB linearization table of the color matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctm_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int TOL_W = 10;
  localparam int REG_W = 16;
  localparam int IDX_W = 2;
  localparam int HSL_FULL = 25600;
  localparam int QUO_W = 17;           // every quotient fits in 17 bits
  localparam int LIN_W = 17;           // Q0.16, full scale 65536
  localparam int XYZ_W = 31;
  localparam int CHR_NUM_W = 47;
  localparam int K_W = 23;             // chroma_sensitivity * 125
  localparam int DXY_W = 23;

  typedef enum logic [1:0] {
    MODE_CHANNEL,
    MODE_RGB,
    MODE_HSL,
    MODE_CHROMA
  } ctm_mode_e;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE,
    REG_CHROMA,
    REG_HUE,
    REG_SAT
  } ctm_reg_e;

  // flags that ride alongside the dividers
  typedef struct packed {
    logic [TOL_W-1:0] tol;
    logic             hit_chan;
    logic             hit_rgb;
    logic [1:0]       gray;
    logic             black;
  } ctm_side_t;

  typedef logic [LIN_W-1:0] lin_rom_t [256];

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t   rom;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] iv;
    for (int i = 0; i < 256; i++) begin
      iv = 64'(i);
      if (i <= 10) begin
        rom[i] = LIN_W'((iv * 64'd6553600 + 64'd164730) / 64'd329460);
      end else begin
        t  = ((iv * 64'd1000 + 64'd14025) << 24) / 64'd269025;
        t2 = (t * t) >> 24;
        lo = 64'd0;
        hi = 64'd1 << 24;
        while (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          p = mid;
          for (int k = 0; k < 4; k++) begin
            p = (p * mid) >> 24;
          end
          if (p <= t2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
        rom[i] = LIN_W'((((t2 * lo) >> 24) + 64'd128) >> 8);
      end
    end
    return rom;
  endfunction

  localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

// ----- design/ctm_prep.sv -----
// ----------------------------------------------------------------------------
// ctm_prep
// Front stages: channel differences with the per-channel and RGB distance checks,
// HSL numerators and denominators, linearization lookup and XYZ sums, ready for the divider bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctm_prep import ctm_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [1:0][2:0][CHANNEL_BITS-1:0]   col_i,
  input  logic [TOL_W-1:0]                    tol_i,
  output logic                                valid_o,
  output ctm_side_t                           side_o,
  output logic [1:0][CHANNEL_BITS+17:0]       hue_num_o,
  output logic [1:0][CHANNEL_BITS+2:0]        hue_den_o,
  output logic [1:0][CHANNEL_BITS+15:0]       sat_num_o,
  output logic [1:0][CHANNEL_BITS:0]          sat_den_o,
  output logic [1:0][CHR_NUM_W-1:0]           cx_num_o,
  output logic [1:0][CHR_NUM_W-1:0]           cy_num_o,
  output logic [1:0][XYZ_W-1:0]               chr_den_o
);

  localparam int CB   = CHANNEL_BITS;
  localparam int NW   = CB + 3;
  localparam int HNW  = CB + 18;
  localparam int SNW  = CB + 16;
  localparam int SQW  = 2 * CB;
  localparam int CMW  = SQW + 2 * TOL_W;
  localparam int CMAX = (1 << CB) - 1;

  // stage 1
  logic                  s1_vld_q;
  logic [CB-1:0]         s1_col_q [2][3];
  logic [CB-1:0]         s1_mx_q  [2];
  logic [CB-1:0]         s1_mn_q  [2];
  logic [CB-1:0]         s1_d_q   [2];
  logic [LIN_W-1:0]      s1_lin_q [2][3];
  logic [CB-1:0]         s1_dif_q [3];
  logic [TOL_W-1:0]      s1_tol_q;
  logic [CB-1:0]         s1_mx_d  [2];
  logic [CB-1:0]         s1_mn_d  [2];
  logic [7:0]            rom_idx  [2][3];

  // stage 2
  logic                  s2_vld_q;
  logic [NW-1:0]         s2_n_q    [2];
  logic [CB:0]           s2_sden_q [2];
  logic [CB-1:0]         s2_d_q    [2];
  logic [1:0]            s2_gray_q;
  logic [XYZ_W-1:0]      s2_x_q [2];
  logic [XYZ_W-1:0]      s2_y_q [2];
  logic [XYZ_W-1:0]      s2_z_q [2];
  logic [SQW-1:0]        s2_sq_q [3];
  logic [2*TOL_W-1:0]    s2_tol2_q;
  logic                  s2_hit_chan_q;
  logic [TOL_W-1:0]      s2_tol_q;
  logic [NW-1:0]         s2_n_d    [2];
  logic [CB:0]           s2_sden_d [2];

  // stage 3
  logic [XYZ_W-1:0]      s3_sum [2];
  logic [SQW+1:0]        sq_sum;

  for (genvar j = 0; j < 2; j++) begin : g_color
    for (genvar c = 0; c < 3; c++) begin : g_chan
      if (CB >= 8) begin : g_down
        assign rom_idx[j][c] = col_i[j][c][CB-1 -: 8];
      end else begin : g_up
        assign rom_idx[j][c] = {col_i[j][c], {(8 - CB){1'b0}}};
      end
    end

    always_comb begin
      logic [CB-1:0] r;
      logic [CB-1:0] g;
      logic [CB-1:0] b;
      r = col_i[j][0];
      g = col_i[j][1];
      b = col_i[j][2];
      s1_mx_d[j] = r;
      s1_mn_d[j] = r;
      if (g > s1_mx_d[j]) s1_mx_d[j] = g;
      if (b > s1_mx_d[j]) s1_mx_d[j] = b;
      if (g < s1_mn_d[j]) s1_mn_d[j] = g;
      if (b < s1_mn_d[j]) s1_mn_d[j] = b;
    end

    // hue numerator before scaling
    always_comb begin
      logic [NW-1:0] r;
      logic [NW-1:0] g;
      logic [NW-1:0] b;
      logic [NW-1:0] d;
      logic [CB:0]   mm;
      r  = NW'(s1_col_q[j][0]);
      g  = NW'(s1_col_q[j][1]);
      b  = NW'(s1_col_q[j][2]);
      d  = NW'(s1_d_q[j]);
      mm = (CB+1)'(s1_mx_q[j]) + (CB+1)'(s1_mn_q[j]);
      if (s1_mx_q[j] == s1_col_q[j][0]) begin
        if (g >= b) begin
          s2_n_d[j] = g - b;
        end else begin
          s2_n_d[j] = (d << 2) + (d << 1) + g - b;
        end
      end else if (s1_mx_q[j] == s1_col_q[j][1]) begin
        s2_n_d[j] = (d << 1) + b - r;
      end else begin
        s2_n_d[j] = (d << 2) + r - g;
      end
      if (mm < (CB+1)'(CMAX)) begin
        s2_sden_d[j] = mm;
      end else begin
        s2_sden_d[j] = ((CB+1)'(CMAX) << 1) - mm;
      end
    end

    assign s3_sum[j] = s2_x_q[j] + s2_y_q[j] + s2_z_q[j];
  end

  assign sq_sum = (SQW+2)'(s2_sq_q[0]) + (SQW+2)'(s2_sq_q[1]) + (SQW+2)'(s2_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      valid_o  <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1
    for (int j = 0; j < 2; j++) begin
      s1_mx_q[j] <= s1_mx_d[j];
      s1_mn_q[j] <= s1_mn_d[j];
      s1_d_q[j]  <= s1_mx_d[j] - s1_mn_d[j];
      for (int c = 0; c < 3; c++) begin
        s1_col_q[j][c] <= col_i[j][c];
        s1_lin_q[j][c] <= LIN_ROM[rom_idx[j][c]];
      end
    end
    for (int c = 0; c < 3; c++) begin
      s1_dif_q[c] <= (col_i[0][c] > col_i[1][c]) ? col_i[0][c] - col_i[1][c]
                                                 : col_i[1][c] - col_i[0][c];
    end
    s1_tol_q <= tol_i;

    // stage 2
    for (int j = 0; j < 2; j++) begin
      s2_n_q[j]    <= s2_n_d[j];
      s2_sden_q[j] <= s2_sden_d[j];
      s2_d_q[j]    <= s1_d_q[j];
      s2_gray_q[j] <= (s1_d_q[j] == '0);
      s2_x_q[j] <= XYZ_W'(4124) * XYZ_W'(s1_lin_q[j][0]) + XYZ_W'(3576) * XYZ_W'(s1_lin_q[j][1])
                 + XYZ_W'(1805) * XYZ_W'(s1_lin_q[j][2]);
      s2_y_q[j] <= XYZ_W'(2126) * XYZ_W'(s1_lin_q[j][0]) + XYZ_W'(7152) * XYZ_W'(s1_lin_q[j][1])
                 + XYZ_W'(722) * XYZ_W'(s1_lin_q[j][2]);
      s2_z_q[j] <= XYZ_W'(193) * XYZ_W'(s1_lin_q[j][0]) + XYZ_W'(1192) * XYZ_W'(s1_lin_q[j][1])
                 + XYZ_W'(9505) * XYZ_W'(s1_lin_q[j][2]);
    end
    for (int c = 0; c < 3; c++) begin
      s2_sq_q[c] <= SQW'(s1_dif_q[c]) * SQW'(s1_dif_q[c]);
    end
    s2_tol2_q     <= (2*TOL_W)'(s1_tol_q) * (2*TOL_W)'(s1_tol_q);
    s2_hit_chan_q <= (TOL_W+CB)'(s1_dif_q[0]) <= (TOL_W+CB)'(s1_tol_q)
                  && (TOL_W+CB)'(s1_dif_q[1]) <= (TOL_W+CB)'(s1_tol_q)
                  && (TOL_W+CB)'(s1_dif_q[2]) <= (TOL_W+CB)'(s1_tol_q);
    s2_tol_q      <= s1_tol_q;

    // stage 3
    for (int j = 0; j < 2; j++) begin
      hue_num_o[j] <= HNW'(s2_n_q[j]) * HNW'(HSL_FULL)
                    + (HNW'(s2_d_q[j]) << 1) + HNW'(s2_d_q[j]);
      hue_den_o[j] <= (NW'(s2_d_q[j]) << 2) + (NW'(s2_d_q[j]) << 1);
      sat_num_o[j] <= SNW'(s2_d_q[j]) * SNW'(HSL_FULL) + SNW'(s2_sden_q[j] >> 1);
      sat_den_o[j] <= s2_sden_q[j];
      cx_num_o[j]  <= (CHR_NUM_W'(s2_x_q[j]) << 16) + CHR_NUM_W'(s3_sum[j] >> 1);
      cy_num_o[j]  <= (CHR_NUM_W'(s2_y_q[j]) << 16) + CHR_NUM_W'(s3_sum[j] >> 1);
      chr_den_o[j] <= s3_sum[j];
    end
    side_o.tol      <= s2_tol_q;
    side_o.hit_chan <= s2_hit_chan_q;
    side_o.hit_rgb  <= CMW'(s2_tol2_q) >= CMW'(sq_sum);
    side_o.gray     <= s2_gray_q;
    side_o.black    <= (s3_sum[0] == '0) || (s3_sum[1] == '0);
  end

endmodule

// ----- design/ctm_div.sv -----
// ----------------------------------------------------------------------------
// ctm_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// word that travels in step with the quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctm_div import ctm_pkg::*; #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int DQUO_W = QUO_W,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DQUO_W-1:0] quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int SW = DEN_W + DQUO_W;
  localparam int W  = (NUM_W > SW) ? NUM_W : SW;

  logic              vld_q  [DQUO_W];
  logic [NUM_W-1:0]  rem_q  [DQUO_W];
  logic [DEN_W-1:0]  den_q  [DQUO_W];
  logic [DQUO_W-1:0] quo_q  [DQUO_W];
  logic [SIDE_W-1:0] side_q [DQUO_W];

  logic              vld_in  [DQUO_W];
  logic [NUM_W-1:0]  rem_in  [DQUO_W];
  logic [DEN_W-1:0]  den_in  [DQUO_W];
  logic [DQUO_W-1:0] quo_in  [DQUO_W];
  logic [SIDE_W-1:0] side_in [DQUO_W];

  for (genvar s = 0; s < DQUO_W; s++) begin : g_stage
    localparam int K = DQUO_W - 1 - s;
    logic [W-1:0] rem_ext;
    logic [W-1:0] sub;

    if (s == 0) begin : g_first
      assign vld_in[s]  = valid_i;
      assign rem_in[s]  = num_i;
      assign den_in[s]  = den_i;
      assign quo_in[s]  = '0;
      assign side_in[s] = side_i;
    end else begin : g_next
      assign vld_in[s]  = vld_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign den_in[s]  = den_q[s-1];
      assign quo_in[s]  = quo_q[s-1];
      assign side_in[s] = side_q[s-1];
    end

    assign rem_ext = W'(rem_in[s]);
    assign sub     = W'(den_in[s]) << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s]  <= den_in[s];
      side_q[s] <= side_in[s];
      if (rem_ext >= sub) begin
        rem_q[s] <= NUM_W'(rem_ext - sub);
        quo_q[s] <= quo_in[s] | (DQUO_W'(1) << K);
      end else begin
        rem_q[s] <= rem_in[s];
        quo_q[s] <= quo_in[s];
      end
    end
  end

  assign valid_o = vld_q[DQUO_W-1];
  assign quo_o   = quo_q[DQUO_W-1];
  assign side_o  = side_q[DQUO_W-1];

endmodule

// ----- design/ctm_decide.sv -----
// ----------------------------------------------------------------------------
// ctm_decide
// Back stages: differences of the quotients, scaling, squaring and the
// final compare picked by the mode register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctm_decide import ctm_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  ctm_side_t                   side_i,
  input  logic [1:0][QUO_W-1:0]       hue_i,
  input  logic [1:0][QUO_W-1:0]       sat_i,
  input  logic [1:0][QUO_W-1:0]       cx_i,
  input  logic [1:0][QUO_W-1:0]       cy_i,
  input  ctm_mode_e                   mode_i,
  input  logic [REG_W-1:0]            chroma_i,
  input  logic [REG_W-1:0]            hue_mod_i,
  input  logic [REG_W-1:0]            sat_mod_i,
  output logic                        done_o,
  output logic                        similar_o
);

  localparam int PW  = QUO_W + K_W;
  localparam int LW  = TOL_W + REG_W;
  localparam int SQW = 2 * DXY_W;

  logic [K_W-1:0]     k_q;

  logic               d1_vld_q;
  ctm_side_t          d1_side_q;
  logic [QUO_W-1:0]   d1_dh_q;
  logic [QUO_W-1:0]   d1_ds_q;
  logic [QUO_W-1:0]   d1_dx_q;
  logic [QUO_W-1:0]   d1_dy_q;
  logic [QUO_W-1:0]   h0;
  logic [QUO_W-1:0]   h1;
  logic [QUO_W-1:0]   sa0;
  logic [QUO_W-1:0]   sa1;

  logic               d2_vld_q;
  ctm_side_t          d2_side_q;
  logic [QUO_W-1:0]   d2_dh_q;
  logic [QUO_W-1:0]   d2_ds_q;
  logic [DXY_W-1:0]   d2_dx_q;
  logic [DXY_W-1:0]   d2_dy_q;
  logic [LW-1:0]      d2_hlim_q;
  logic [LW-1:0]      d2_slim_q;
  logic [2*TOL_W-1:0] d2_tol2_q;
  logic [PW-1:0]      px;
  logic [PW-1:0]      py;

  logic               d3_vld_q;
  ctm_side_t          d3_side_q;
  logic               d3_hit_hsl_q;
  logic [SQW-1:0]     d3_dx2_q;
  logic [SQW-1:0]     d3_dy2_q;
  logic [SQW:0]       d3_lim2_q;
  logic               hit_chr;
  logic               hit_sel;

  // gray colors have hue and saturation of zero
  assign h0  = side_i.gray[0] ? '0 : hue_i[0];
  assign h1  = side_i.gray[1] ? '0 : hue_i[1];
  assign sa0 = side_i.gray[0] ? '0 : sat_i[0];
  assign sa1 = side_i.gray[1] ? '0 : sat_i[1];

  assign px = PW'(d1_dx_q) * PW'(k_q);
  assign py = PW'(d1_dy_q) * PW'(k_q);

  assign hit_chr = !d3_side_q.black
                && ((SQW+1)'(d3_dx2_q) + (SQW+1)'(d3_dy2_q) <= d3_lim2_q);

  always_comb begin
    case (mode_i)
      MODE_CHANNEL: hit_sel = d3_side_q.hit_chan;
      MODE_RGB:     hit_sel = d3_side_q.hit_rgb;
      MODE_HSL:     hit_sel = d3_hit_hsl_q;
      MODE_CHROMA:  hit_sel = hit_chr;
      default:      hit_sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
      d3_vld_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      d1_vld_q <= valid_i;
      d2_vld_q <= d1_vld_q;
      d3_vld_q <= d2_vld_q;
      done_o   <= d3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= K_W'(chroma_i) * K_W'(125);

    d1_side_q <= side_i;
    d1_dh_q   <= (h0 > h1) ? h0 - h1 : h1 - h0;
    d1_ds_q   <= (sa0 > sa1) ? sa0 - sa1 : sa1 - sa0;
    d1_dx_q   <= (cx_i[0] > cx_i[1]) ? cx_i[0] - cx_i[1] : cx_i[1] - cx_i[0];
    d1_dy_q   <= (cy_i[0] > cy_i[1]) ? cy_i[0] - cy_i[1] : cy_i[1] - cy_i[0];

    d2_side_q <= d1_side_q;
    d2_dh_q   <= d1_dh_q;
    d2_ds_q   <= d1_ds_q;
    d2_dx_q   <= DXY_W'(px >> 16);
    d2_dy_q   <= DXY_W'(py >> 16);
    d2_hlim_q <= LW'(d1_side_q.tol) * LW'(hue_mod_i);
    d2_slim_q <= LW'(d1_side_q.tol) * LW'(sat_mod_i);
    d2_tol2_q <= (2*TOL_W)'(d1_side_q.tol) * (2*TOL_W)'(d1_side_q.tol);

    d3_side_q    <= d2_side_q;
    d3_hit_hsl_q <= (LW'(d2_dh_q) <= d2_hlim_q) && (LW'(d2_ds_q) <= d2_slim_q);
    d3_dx2_q     <= SQW'(d2_dx_q) * SQW'(d2_dx_q);
    d3_dy2_q     <= SQW'(d2_dy_q) * SQW'(d2_dy_q);
    d3_lim2_q    <= (SQW+1)'(d2_tol2_q) << 16;

    similar_o <= hit_sel;
  end

  a_black_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d3_vld_q && mode_i == MODE_CHROMA && d3_side_q.black) |=> !similar_o)
    else $error("black color reported as chromaticity match");

  a_chan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d3_vld_q && mode_i == MODE_CHANNEL) |=> (similar_o == $past(d3_side_q.hit_chan)))
    else $error("per-channel result lost on its way to the output");

  a_rgb_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d3_vld_q && mode_i == MODE_RGB) |=> (similar_o == $past(d3_side_q.hit_rgb)))
    else $error("rgb distance result lost on its way to the output");

endmodule

// ----- design/color_tolerance_match.sv -----
// ----------------------------------------------------------------------------
// color_tolerance_match
// Compares two RGB colors against a tolerance in one of four modes.
// ----------------------------------------------------------------------------
// Fully pipelined: a new pair of colors may be started every cycle, busy
// stays low, and each result comes out as a one-cycle done_o strobe. A pair
// passes 3 front stages, the divider bank (one quotient bit per stage, 17
// stages) and 4 back stages. The receiver cannot stall the pipeline.
// Configuration words are taken every cycle (cfg_ready_o is high) and must
// be written only while no comparison is in flight.
`timescale 1ns / 1ps

module color_tolerance_match import ctm_pkg::*; #(
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [CHANNEL_BITS-1:0] first_red_i,
  input  logic [CHANNEL_BITS-1:0] first_green_i,
  input  logic [CHANNEL_BITS-1:0] first_blue_i,
  input  logic [CHANNEL_BITS-1:0] second_red_i,
  input  logic [CHANNEL_BITS-1:0] second_green_i,
  input  logic [CHANNEL_BITS-1:0] second_blue_i,
  input  logic [TOL_W-1:0]        tolerance_i,
  output logic                    done_o,
  output logic                    similar_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [REG_W-1:0]        cfg_data_i
);

  localparam int CB = CHANNEL_BITS;
  localparam int SIDE_W = $bits(ctm_side_t);

  ctm_mode_e          mode_q;
  logic [REG_W-1:0]   chroma_q;
  logic [REG_W-1:0]   hue_mod_q;
  logic [REG_W-1:0]   sat_mod_q;

  logic [1:0][2:0][CB-1:0] col;
  logic                    pre_vld;
  ctm_side_t               pre_side;
  logic [1:0][CB+17:0]     hue_num;
  logic [1:0][CB+2:0]      hue_den;
  logic [1:0][CB+15:0]     sat_num;
  logic [1:0][CB:0]        sat_den;
  logic [1:0][CHR_NUM_W-1:0] cx_num;
  logic [1:0][CHR_NUM_W-1:0] cy_num;
  logic [1:0][XYZ_W-1:0]   chr_den;

  logic                    div_vld;
  logic [SIDE_W-1:0]       div_side;
  logic [1:0][QUO_W-1:0]   hue_q;
  logic [1:0][QUO_W-1:0]   sat_q;
  logic [1:0][QUO_W-1:0]   cx_q;
  logic [1:0][QUO_W-1:0]   cy_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_RGB;
      chroma_q  <= REG_W'(1024);
      hue_mod_q <= REG_W'(51);
      sat_mod_q <= REG_W'(51);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ctm_reg_e'(cfg_index_i))
        REG_MODE:   mode_q    <= ctm_mode_e'(cfg_data_i[1:0]);
        REG_CHROMA: chroma_q  <= cfg_data_i;
        REG_HUE:    hue_mod_q <= cfg_data_i;
        REG_SAT:    sat_mod_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  assign col[0][0] = first_red_i;
  assign col[0][1] = first_green_i;
  assign col[0][2] = first_blue_i;
  assign col[1][0] = second_red_i;
  assign col[1][1] = second_green_i;
  assign col[1][2] = second_blue_i;

  ctm_prep #(.CHANNEL_BITS(CB)) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .col_i     (col),
    .tol_i     (tolerance_i),
    .valid_o   (pre_vld),
    .side_o    (pre_side),
    .hue_num_o (hue_num),
    .hue_den_o (hue_den),
    .sat_num_o (sat_num),
    .sat_den_o (sat_den),
    .cx_num_o  (cx_num),
    .cy_num_o  (cy_num),
    .chr_den_o (chr_den)
  );

  // the first hue divider carries valid and the flags for the whole bank
  ctm_div #(.NUM_W(CB+18), .DEN_W(CB+3), .SIDE_W(SIDE_W)) u_div_hue0 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (pre_vld),
    .num_i (hue_num[0]), .den_i (hue_den[0]), .side_i (pre_side),
    .valid_o (div_vld), .quo_o (hue_q[0]), .side_o (div_side)
  );

  ctm_div #(.NUM_W(CB+18), .DEN_W(CB+3)) u_div_hue1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (pre_vld),
    .num_i (hue_num[1]), .den_i (hue_den[1]), .side_i (1'b0),
    .valid_o (), .quo_o (hue_q[1]), .side_o ()
  );

  for (genvar j = 0; j < 2; j++) begin : g_bank
    ctm_div #(.NUM_W(CB+16), .DEN_W(CB+1)) u_div_sat (
      .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (pre_vld),
      .num_i (sat_num[j]), .den_i (sat_den[j]), .side_i (1'b0),
      .valid_o (), .quo_o (sat_q[j]), .side_o ()
    );

    ctm_div #(.NUM_W(CHR_NUM_W), .DEN_W(XYZ_W)) u_div_cx (
      .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (pre_vld),
      .num_i (cx_num[j]), .den_i (chr_den[j]), .side_i (1'b0),
      .valid_o (), .quo_o (cx_q[j]), .side_o ()
    );

    ctm_div #(.NUM_W(CHR_NUM_W), .DEN_W(XYZ_W)) u_div_cy (
      .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (pre_vld),
      .num_i (cy_num[j]), .den_i (chr_den[j]), .side_i (1'b0),
      .valid_o (), .quo_o (cy_q[j]), .side_o ()
    );
  end

  ctm_decide u_decide (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (div_vld),
    .side_i    (ctm_side_t'(div_side)),
    .hue_i     (hue_q),
    .sat_i     (sat_q),
    .cx_i      (cx_q),
    .cy_i      (cy_q),
    .mode_i    (mode_q),
    .chroma_i  (chroma_q),
    .hue_mod_i (hue_mod_q),
    .sat_mod_i (sat_mod_q),
    .done_o    (done_o),
    .similar_o (similar_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_tolerance_match testbench
// Drives color pairs through the matcher in all four modes under changing
// register settings. A bit-exact predictor in the scoreboard works out each
// match flag and checks every done_o word against it in order.
// ----------------------------------------------------------------------------

module testbench;
  import ctm_pkg::*;

  typedef struct {
    logic [7:0]       r1, g1, b1, r2, g2, b2;
    logic [TOL_W-1:0] tol;
  } color_pair_t;

  class match_scoreboard;
    bit          expected_q[$];
    int          errors;
    ctm_mode_e   mode;
    int unsigned chroma_sens, hue_mod, sat_mod;
    longint unsigned lin_light[256];

    function new();
      longint unsigned t, t2, lo, hi, mid, p;
      mode = MODE_RGB;
      chroma_sens = 1024;
      hue_mod = 51;
      sat_mod = 51;
      errors = 0;
      // srgb to linear light, q0.16
      for (int i = 0; i < 256; i++) begin
        if (i <= 10) begin
          lin_light[i] = (longint'(i) * 6553600 + 164730) / 329460;
        end else begin
          t  = ((longint'(i) * 1000 + 14025) << 24) / 269025;
          t2 = (t * t) >> 24;
          lo = 0;
          hi = 64'd1 << 24;
          while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            p = mid;
            repeat (4) p = (p * mid) >> 24;
            if (p <= t2) lo = mid;
            else hi = mid - 1;
          end
          lin_light[i] = (((t2 * lo) >> 24) + 128) >> 8;
        end
      end
    endfunction

    function void write_reg(ctm_reg_e idx, logic [REG_W-1:0] data);
      case (idx)
        REG_MODE:   mode = ctm_mode_e'(data[1:0]);
        REG_CHROMA: chroma_sens = data;
        REG_HUE:    hue_mod = data;
        REG_SAT:    sat_mod = data;
        default: ;
      endcase
    endfunction

    function int unsigned absdiff(longint unsigned a, longint unsigned b);
      return 32'((a > b) ? a - b : b - a);
    endfunction

    function void hue_sat(int unsigned r, int unsigned g, int unsigned b,
                          output int unsigned hue, output int unsigned sat);
      int unsigned mx, mn, d, n, den;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      if (d == 0) begin
        hue = 0;
        sat = 0;
        return;
      end
      if (mx == r) n = (g >= b) ? g - b : 6 * d - (b - g);
      else if (mx == g) n = 2 * d + b - r;
      else n = 4 * d + r - g;
      hue = 32'((longint'(n) * HSL_FULL + 3 * d) / (6 * d));
      den = (mx + mn < 255) ? mx + mn : 510 - mx - mn;
      sat = 32'((longint'(d) * HSL_FULL + den / 2) / den);
    endfunction

    // false for black, which has no chromaticity
    function bit chromaticity(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              output longint unsigned cx, output longint unsigned cy);
      longint unsigned lr, lg, lb, x, y, z, s;
      lr = lin_light[r]; lg = lin_light[g]; lb = lin_light[b];
      x = 4124 * lr + 3576 * lg + 1805 * lb;
      y = 2126 * lr + 7152 * lg + 722 * lb;
      z = 193 * lr + 1192 * lg + 9505 * lb;
      s = x + y + z;
      if (s == 0) return 0;
      cx = (x * 65536 + s / 2) / s;
      cy = (y * 65536 + s / 2) / s;
      return 1;
    endfunction

    function bit predict_match(color_pair_t c);
      longint unsigned dr, dg, db, tl, xa, ya, xb, yb, k, dx, dy, lim;
      int unsigned ha, sa, hb, sb;
      bit hit;
      dr = absdiff(c.r1, c.r2);
      dg = absdiff(c.g1, c.g2);
      db = absdiff(c.b1, c.b2);
      tl = c.tol;
      hit = 0;
      case (mode)
        MODE_CHANNEL: hit = dr <= tl && dg <= tl && db <= tl;
        MODE_RGB:     hit = dr * dr + dg * dg + db * db <= tl * tl;
        MODE_HSL: begin
          hue_sat(c.r1, c.g1, c.b1, ha, sa);
          hue_sat(c.r2, c.g2, c.b2, hb, sb);
          hit = absdiff(ha, hb) <= tl * hue_mod && absdiff(sa, sb) <= tl * sat_mod;
        end
        default: begin
          if (chromaticity(c.r1, c.g1, c.b1, xa, ya) &&
              chromaticity(c.r2, c.g2, c.b2, xb, yb)) begin
            k = longint'(chroma_sens) * 125;
            dx = (longint'(absdiff(xa, xb)) * k) >> 16;
            dy = (longint'(absdiff(ya, yb)) * k) >> 16;
            lim = tl << 8;
            hit = dx * dx + dy * dy <= lim * lim;
          end
        end
      endcase
      return hit;
    endfunction

    function void note_pair(color_pair_t c);
      expected_q.push_back(predict_match(c));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic similar);
      bit want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word, similar=%0b", similar));
      end else begin
        want = expected_q.pop_front();
        if (similar !== want) report($sformatf("similar=%0b, want %0b", similar, want));
      end
    endtask
  endclass

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             start = 0;
  logic             busy;
  logic [7:0]       first_red_i = 0, first_green_i = 0, first_blue_i = 0;
  logic [7:0]       second_red_i = 0, second_green_i = 0, second_blue_i = 0;
  logic [TOL_W-1:0] tolerance_i = 0;
  logic             done_o, similar_o;
  logic             cfg_valid_i = 0;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = REG_MODE;
  logic [REG_W-1:0] cfg_data_i = 0;

  match_scoreboard sb = new();
  int gap_pct = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  color_tolerance_match u_dut (
    .clk_i, .rst_ni, .start, .busy,
    .first_red_i, .first_green_i, .first_blue_i,
    .second_red_i, .second_green_i, .second_blue_i,
    .tolerance_i, .done_o, .similar_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always @(posedge clk_i) begin
    color_pair_t c;
    bit moved;
    if (rst_ni) begin
      moved = 0;
      if (start && !busy) begin
        c.r1 = first_red_i; c.g1 = first_green_i; c.b1 = first_blue_i;
        c.r2 = second_red_i; c.g2 = second_green_i; c.b2 = second_blue_i;
        c.tol = tolerance_i;
        sb.note_pair(c);
        moved = 1;
      end
      if (done_o) begin
        sb.check_result(similar_o);
        moved = 1;
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1;
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles > 3000) begin
        $display("watchdog expired");
        $display("FAIL");
        $finish;
      end
    end
  end

  // each cycle the sender idles with probability gap_pct percent
  task send_pair(color_pair_t c);
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    first_red_i <= c.r1; first_green_i <= c.g1; first_blue_i <= c.b1;
    second_red_i <= c.r2; second_green_i <= c.g2; second_blue_i <= c.b2;
    tolerance_i <= c.tol;
    start <= 1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // registers only change with the pipeline drained
  task write_reg(ctm_reg_e idx, logic [REG_W-1:0] data);
    start <= 0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [7:0] nudge(logic [7:0] v);
    int n;
    n = int'(v) + $urandom_range(0, 16) - 8;
    if (n < 0) n = 0;
    if (n > 255) n = 255;
    return 8'(n);
  endfunction

  function automatic color_pair_t make_pair(int r1, int g1, int b1,
                                            int r2, int g2, int b2, int tol);
    color_pair_t c;
    c.r1 = 8'(r1); c.g1 = 8'(g1); c.b1 = 8'(b1);
    c.r2 = 8'(r2); c.g2 = 8'(g2); c.b2 = 8'(b2);
    c.tol = TOL_W'(tol);
    return c;
  endfunction

  function automatic color_pair_t random_pair();
    color_pair_t c;
    logic [7:0] gray;
    c.r1 = 8'($urandom); c.g1 = 8'($urandom); c.b1 = 8'($urandom);
    c.r2 = 8'($urandom); c.g2 = 8'($urandom); c.b2 = 8'($urandom);
    case ($urandom_range(0, 5))
      0, 1: begin
        c.r2 = nudge(c.r1); c.g2 = nudge(c.g1); c.b2 = nudge(c.b1);
      end
      2: begin
        gray = 8'($urandom);
        c.r1 = gray; c.g1 = gray; c.b1 = gray;
      end
      3: begin
        c.r2 = c.r1; c.g2 = c.g1; c.b2 = c.b1;
      end
      default: ;
    endcase
    c.tol = ($urandom_range(0, 2) == 0) ? TOL_W'($urandom_range(0, 1023))
                                        : TOL_W'($urandom_range(0, 40));
    return c;
  endfunction

  function automatic logic [REG_W-1:0] random_modifier();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return REG_W'($urandom_range(0, 128));
      default: return REG_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: corners of every mode, grays and black
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, 16'hFFFC | REG_W'(m));
      send_pair(make_pair(0, 0, 0, 255, 255, 255, 1023));
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(255, 0, 0, 250, 5, 3, 5));
      send_pair(make_pair(128, 128, 128, 0, 200, 50, 100));
      if (m == 3) send_pair(make_pair(0, 0, 0, 10, 10, 10, 1023));
    end
    write_reg(REG_CHROMA, 16'hFFFF);
    write_reg(REG_HUE, 16'hFFFF);
    write_reg(REG_SAT, 16'h0000);
    send_pair(make_pair(255, 255, 255, 0, 0, 255, 1023));
    write_reg(REG_MODE, REG_W'(MODE_HSL));
    send_pair(make_pair(255, 255, 0, 0, 255, 255, 1023));

    for (int phase = 0; phase < 12; phase++) begin
      gap_pct = (phase < 4) ? 9 : (phase < 8) ? 57 : 0;
      write_reg(REG_MODE, (16'($urandom) & 16'hFFFC) | REG_W'(phase % 4));
      write_reg(REG_CHROMA, random_modifier());
      write_reg(REG_HUE, random_modifier());
      write_reg(REG_SAT, random_modifier());
      repeat (95) send_pair(random_pair());
    end
    start <= 0;

    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
